### design/ntp_seconds_to_local_calendar_core_assert.svh
// assertion helpers for the calendar core, clocked on clk, off during reset
`ifndef NTP_SECONDS_TO_LOCAL_CALENDAR_CORE_ASSERT_SVH
`define NTP_SECONDS_TO_LOCAL_CALENDAR_CORE_ASSERT_SVH

// same-cycle implication
`define NTPCAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntpcal same-cycle check failed");

// next-cycle implication
`define NTPCAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntpcal next-cycle check failed");

`endif

### design/ntpcal_pkg.sv
package ntpcal_pkg;

  localparam int ZONE_COUNT  = 50;
  localparam int SECS_PER_DAY = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN = 60;
  localparam int EPOCH_YEAR  = 1900;
  localparam int ZONE_RESET  = 21;

  // each split pass: a quotient step, then a remainder step
  localparam int DIV_STEPS = 2;

  localparam int WORK_W = 33;
  localparam int DAYS_W = 17;

  // reciprocals: days = (secs >> 7) / 675, hours = (rem >> 4) / 225,
  // minutes = (rem >> 2) / 15, each exact over its operand range
  localparam logic [26:0] DAY_RECIP  = 27'd101806633;  // ceil(2^36 / 675)
  localparam logic [13:0] HOUR_RECIP = 14'd9321;       // ceil(2^21 / 225)
  localparam logic [10:0] MIN_RECIP  = 11'd1093;       // ceil(2^14 / 15)

  localparam logic [16:0] DAY_DIV  = 17'(SECS_PER_DAY);
  localparam logic [16:0] HOUR_DIV = 17'(SECS_PER_HOUR);
  localparam logic [16:0] MIN_DIV  = 17'(SECS_PER_MIN);

  localparam int ZONE_OFFSET [ZONE_COUNT] = '{
    -43200, -39600, -36000, -34200, -32400, -28800, -28800, -25200, -25200, -21600,
    -21600, -18000, -18000, -18000, -16200, -14400, -14400, -12600, -10800, -7200,
    -3600, 0, 0, 3600, 3600, 3600, 7200, 7200, 10800, 10800,
    12600, 14400, 16200, 18000, 19800, 20700, 21600, 23400, 25200, 28800,
    32400, 34200, 36000, 37800, 39600, 41400, 43200, 46500, 46800, 50400
  };

  typedef enum logic [1:0] {
    PH_DAY  = 2'd0,
    PH_HOUR = 2'd1,
    PH_MIN  = 2'd2
  } ntpcal_phase_t;

  typedef struct packed {
    logic          load;
    logic          div_step;
    logic          div_last;
    ntpcal_phase_t phase;
    logic          year_step;
    logic          month_step;
    logic          emit;
  } ntpcal_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } ntpcal_sts_t;

  function automatic logic signed [16:0] zone_offset(input logic [5:0] idx);
    logic signed [16:0] off;
    off = '0;
    if (idx < 6'(ZONE_COUNT)) begin
      off = 17'(ZONE_OFFSET[idx]);
    end
    return off;
  endfunction

  // ylo = year mod 4, m100 = year mod 100, c2 = (year / 100) mod 4
  function automatic logic is_leap(input logic [1:0] ylo, input logic [6:0] m100,
                                   input logic [1:0] c2);
    return (ylo == 2'd0) && ((m100 != 7'd0) || (c2 == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd2:                        len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
      default:                     len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### design/ntpcal_ctrl.sv
module ntpcal_ctrl
  import ntpcal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ntpcal_sts_t sts,
  output ntpcal_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_YEAR  = 5'b00100,
    S_MONTH = 5'b01000,
    S_EMIT  = 5'b10000
  } ntpcal_state_t;

  ntpcal_state_t state_r, state_nxt;
  ntpcal_phase_t phase_r, phase_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.phase = phase_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          phase_nxt = PH_DAY;
          cnt_nxt   = 5'(DIV_STEPS - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (cnt_r == 5'd0);
        if (cnt_r == 5'd0) begin
          unique case (phase_r)
            PH_DAY: begin
              phase_nxt = PH_HOUR;
              cnt_nxt   = 5'(DIV_STEPS - 1);
            end
            PH_HOUR: begin
              phase_nxt = PH_MIN;
              cnt_nxt   = 5'(DIV_STEPS - 1);
            end
            default: begin
              state_nxt = S_YEAR;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_YEAR: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_DAY;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/ntpcal_dp.sv
module ntpcal_dp
  import ntpcal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic [31:0] in_ntp_seconds,
  input  ntpcal_cmd_t cmd,
  output ntpcal_sts_t sts,
  output logic [10:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic        out_clamped
);

  logic [5:0]        zone_r;
  logic [WORK_W-1:0] work_r;
  logic [DAYS_W-1:0] q_r;
  logic [DAYS_W-1:0] days_r;
  logic [4:0]        hour_r;
  logic [5:0]        minute_r;
  logic              clamped_r;
  logic [10:0]       year_r;
  logic [6:0]        ymod100_r;
  logic [1:0]        cent_r;
  logic [3:0]        month_r;

  logic signed [16:0] off;
  logic [33:0]        loc_sum;
  logic [52:0]        day_prod;
  logic [26:0]        hour_prod;
  logic [20:0]        min_prod;
  logic [DAYS_W-1:0]  q_calc;
  logic [16:0]        div_k;
  logic [33:0]        back_prod;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;

  assign off     = zone_offset(zone_r);
  assign loc_sum = {2'b00, in_ntp_seconds} + {{17{off[16]}}, off};

  // quotient by reciprocal multiply on the pre-shifted remainder
  assign day_prod  = 53'(work_r[32:7]) * 53'(DAY_RECIP);
  assign hour_prod = 27'(work_r[16:4]) * 27'(HOUR_RECIP);
  assign min_prod  = 21'(work_r[11:2]) * 21'(MIN_RECIP);

  always_comb begin
    unique case (cmd.phase)
      PH_DAY: begin
        q_calc = day_prod[52:36];
        div_k  = DAY_DIV;
      end
      PH_HOUR: begin
        q_calc = DAYS_W'(hour_prod[26:21]);
        div_k  = HOUR_DIV;
      end
      default: begin
        q_calc = DAYS_W'(min_prod[20:14]);
        div_k  = MIN_DIV;
      end
    endcase
  end

  // quotient times divisor, taken off the remainder in the remainder step
  assign back_prod = 34'(q_r) * 34'(div_k);

  assign leap = is_leap(year_r[1:0], ymod100_r, cent_r);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month_r, leap);

  assign sts.year_more  = (days_r >= DAYS_W'(ylen));
  assign sts.month_more = (month_r < 4'd12) && (days_r >= DAYS_W'(mlen));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= 6'(ZONE_RESET);
    end else if (cfg_we) begin
      zone_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r    <= loc_sum[33] ? '0 : loc_sum[WORK_W-1:0];
      clamped_r <= loc_sum[33];
      q_r       <= '0;
      year_r    <= 11'(EPOCH_YEAR);
      ymod100_r <= 7'd0;
      cent_r    <= 2'(EPOCH_YEAR / 100);
      month_r   <= 4'd1;
    end else if (cmd.div_step) begin
      if (cmd.div_last) begin
        work_r <= work_r - back_prod[WORK_W-1:0];
        unique case (cmd.phase)
          PH_DAY: begin
            days_r <= q_r;
          end
          PH_HOUR: begin
            hour_r <= q_r[4:0];
          end
          default: begin
            minute_r <= q_r[5:0];
          end
        endcase
      end else begin
        q_r <= q_calc;
      end
    end else if (cmd.year_step) begin
      days_r <= days_r - DAYS_W'(ylen);
      year_r <= year_r + 11'd1;
      if (ymod100_r == 7'd99) begin
        ymod100_r <= 7'd0;
        cent_r    <= cent_r + 2'd1;
      end else begin
        ymod100_r <= ymod100_r + 7'd1;
      end
    end else if (cmd.month_step) begin
      days_r  <= days_r - DAYS_W'(mlen);
      month_r <= month_r + 4'd1;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_year    <= year_r;
      out_month   <= month_r;
      out_day     <= days_r[4:0] + 5'd1;
      out_hour    <= hour_r;
      out_minute  <= minute_r;
      out_second  <= work_r[5:0];
      out_clamped <= clamped_r;
    end
  end

endmodule

### design/ntp_seconds_to_local_calendar_core.sv
// channel   direction  handshake             word
// in_       input      in_valid/in_ready     in_ntp_seconds
// out_      output     out_valid/out_ready   out_year .. out_clamped
// cfg_      input      cfg_we                cfg_wdata (zone index)
//
// one word in flight; in_ready is high only while the converter is idle
// per word: an accept, then a quotient and a remainder step for days, hours, minutes,
//   then a year walk (a step per year past 1900), a month walk and emit; the year walk dominates
// a finished word sits in the output register, so a new word is taken while it waits
// rst_n is synchronous active low; zone index resets to 21 (utc)
// an output stall holds the next word at emit, and in_ready stays low until it clears
module ntp_seconds_to_local_calendar_core
  import ntpcal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  // input word
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_ntp_seconds,
  // result word
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic        out_clamped
);

  ntpcal_cmd_t cmd;
  ntpcal_sts_t sts;

  // sequencer: accept, three split passes, year walk, month walk, emit
  ntpcal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // zone offset add and clamp, reciprocal-multiply splitter, calendar counters
  ntpcal_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ntp_seconds (in_ntp_seconds),
    .cmd            (cmd),
    .sts            (sts),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_hour       (out_hour),
    .out_minute     (out_minute),
    .out_second     (out_second),
    .out_clamped    (out_clamped)
  );

`include "ntp_seconds_to_local_calendar_core_assert.svh"

  // converter is busy right after taking a word
  `NTPCAL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // calendar fields stay in range
  `NTPCAL_ASSERT_NOW(a_date_range, out_valid,
    (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1))
  // time-of-day fields stay in range
  `NTPCAL_ASSERT_NOW(a_time_range, out_valid,
    (out_hour < 5'd24) && (out_minute < 6'd60) && (out_second < 6'd60))

endmodule
